@@ rtl/opsa_pkg.sv @@
package opsa_pkg;

  // Matrix shape: fixed by the four basis values on the input beat
  localparam int ORDER      = 4;
  localparam int ENTRIES    = ORDER * ORDER;
  localparam int ENT_W      = 4;
  localparam int ACC_W      = 48;
  localparam int CFG_W      = 13;

  localparam int GRID_CELLS_DEF = 4096;
  localparam logic [CFG_W-1:0] CELLS_RESET = 13'd4096;

  typedef enum logic [1:0] {
    STATUS_DONE = 2'd0,
    STATUS_DROP = 2'd1,
    STATUS_SAT  = 2'd2
  } status_t;

  typedef enum logic [0:0] {
    ACT_ACCUM = 1'b0,
    ACT_READ  = 1'b1
  } action_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ACC,
    ST_DRAIN,
    ST_RD_ISSUE,
    ST_RD_DATA,
    ST_RES
  } state_t;

endpackage

@@ rtl/opsa_ram.sv @@
module opsa_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port; rdata holds while re is low
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/outer_product_scatter_accumulate.sv @@
// Weighted Hermitian outer-product accumulator over a grid of 4x4 complex
// cells held in one block RAM (real and imaginary parts side by side, one
// entry per matrix element). After reset the block sweeps the RAM to zero,
// one entry a cycle, and takes no input beat until that is done. An
// accumulate beat runs one read-modify-write per matrix entry through a
// three-stage pipe (products, weighting, round and saturating add), then
// gives one status beat. A read beat streams the 16 entries, each through
// an issue state and a data state for the RAM read, and holds in the data
// state while the output is stalled. A dropped index goes straight to the
// status beat. One item is worked at a time; the output register lets the
// next input beat in while a status beat waits.
module outer_product_scatter_accumulate #(
  parameter int GRID_CELLS = opsa_pkg::GRID_CELLS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [12:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        action,
  input  logic signed [12:0] cell_index,
  input  logic [15:0] weight,
  input  logic signed [15:0] basis_0_re,
  input  logic signed [15:0] basis_0_im,
  input  logic signed [15:0] basis_1_re,
  input  logic signed [15:0] basis_1_im,
  input  logic signed [15:0] basis_2_re,
  input  logic signed [15:0] basis_2_im,
  input  logic signed [15:0] basis_3_re,
  input  logic signed [15:0] basis_3_im,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [1:0]  row,
  output logic [1:0]  col,
  output logic signed [47:0] value_re,
  output logic signed [47:0] value_im,
  output logic        last
);

  localparam int CELL_W = (GRID_CELLS > 1) ? $clog2(GRID_CELLS) : 1;
  localparam int DEPTH  = GRID_CELLS * opsa_pkg::ENTRIES;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int ENT_W  = opsa_pkg::ENT_W;
  localparam int ACC_W  = opsa_pkg::ACC_W;
  localparam logic [ENT_W-1:0]  ENT_LAST  = ENT_W'(opsa_pkg::ENTRIES - 1);
  localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(DEPTH - 1);
  localparam logic [16:0]       GRID_LIM  = 17'(GRID_CELLS);

  opsa_pkg::state_t state, state_next;

  logic [12:0]       cells_in_use;
  logic [ADDR_W-1:0] clr_addr;
  logic [CELL_W-1:0] cell_sel;
  logic [ENT_W-1:0]  cnt;
  logic [15:0]       wgt;
  logic signed [15:0] b_re [opsa_pkg::ORDER];
  logic signed [15:0] b_im [opsa_pkg::ORDER];
  logic              sat;
  opsa_pkg::status_t res_status;

  // pipe registers
  logic                     v1, v2;
  logic [ADDR_W-1:0]        a1, a2;
  logic signed [32:0]       s1_re, s1_im;
  logic signed [49:0]       s2_re, s2_im;
  logic signed [ACC_W-1:0]  s2_acc_re, s2_acc_im;

  logic              accept, idx_ok, out_free, rd_issue;
  logic [ADDR_W-1:0] raddr;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [2*ACC_W-1:0] ram_wdata, ram_rdata;

  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // index check: non-negative, below cells_in_use and below the grid size
  always_comb begin
    idx_ok = !cell_index[12]
             && ({5'd0, cell_index[11:0]} < {4'd0, cells_in_use})
             && ({5'd0, cell_index[11:0]} < GRID_LIM);
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      opsa_pkg::ST_CLEAR: begin
        if (clr_addr == ADDR_LAST) state_next = opsa_pkg::ST_IDLE;
      end
      opsa_pkg::ST_IDLE: begin
        if (accept) begin
          if (!idx_ok) state_next = opsa_pkg::ST_RES;
          else if (action == opsa_pkg::ACT_READ) state_next = opsa_pkg::ST_RD_ISSUE;
          else state_next = opsa_pkg::ST_ACC;
        end
      end
      opsa_pkg::ST_ACC: begin
        if (cnt == ENT_LAST) state_next = opsa_pkg::ST_DRAIN;
      end
      opsa_pkg::ST_DRAIN: begin
        if (!v1 && !v2) state_next = opsa_pkg::ST_RES;
      end
      opsa_pkg::ST_RD_ISSUE: begin
        state_next = opsa_pkg::ST_RD_DATA;
      end
      opsa_pkg::ST_RD_DATA: begin
        if (out_free) begin
          state_next = (cnt == ENT_LAST) ? opsa_pkg::ST_IDLE : opsa_pkg::ST_RD_ISSUE;
        end
      end
      opsa_pkg::ST_RES: begin
        if (out_free) state_next = opsa_pkg::ST_IDLE;
      end
      default: state_next = opsa_pkg::ST_CLEAR;
    endcase
  end

  // state-driven controls
  always_comb begin
    in_stall = (state != opsa_pkg::ST_IDLE);
    rd_issue = (state == opsa_pkg::ST_ACC) || (state == opsa_pkg::ST_RD_ISSUE);
    raddr    = ADDR_W'({cell_sel, cnt});
  end

  // stage 3: round the weighted product, saturating add, write back
  logic signed [50:0]       rnd_re, rnd_im;
  logic signed [38:0]       d_re, d_im;
  logic signed [ACC_W:0]    sum_re, sum_im;
  logic signed [ACC_W-1:0]  new_re, new_im;
  logic                     ovf_re, ovf_im;

  always_comb begin
    rnd_re = 51'(s2_re) + 51'sd2048;
    rnd_im = 51'(s2_im) + 51'sd2048;
    d_re   = rnd_re[50:12];
    d_im   = rnd_im[50:12];
    sum_re = (ACC_W+1)'(s2_acc_re) + (ACC_W+1)'(d_re);
    sum_im = (ACC_W+1)'(s2_acc_im) + (ACC_W+1)'(d_im);
    ovf_re = sum_re[ACC_W] != sum_re[ACC_W-1];
    ovf_im = sum_im[ACC_W] != sum_im[ACC_W-1];
    new_re = ovf_re ? {sum_re[ACC_W], {(ACC_W-1){~sum_re[ACC_W]}}} : sum_re[ACC_W-1:0];
    new_im = ovf_im ? {sum_im[ACC_W], {(ACC_W-1){~sum_im[ACC_W]}}} : sum_im[ACC_W-1:0];
  end

  // RAM write port: clearing sweep or pipe write-back
  always_comb begin
    if (state == opsa_pkg::ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = '0;
    end else begin
      ram_we    = v2;
      ram_waddr = a2;
      ram_wdata = {new_re, new_im};
    end
  end

  // stage 1: conj(b[l]) * b[l'] for the entry being issued
  logic signed [15:0] bl_re, bl_im, bp_re, bp_im;
  logic signed [31:0] p_rr, p_ii, p_ri, p_ir;

  always_comb begin
    bl_re = b_re[cnt[3:2]];
    bl_im = b_im[cnt[3:2]];
    bp_re = b_re[cnt[1:0]];
    bp_im = b_im[cnt[1:0]];
    p_rr  = bl_re * bp_re;
    p_ii  = bl_im * bp_im;
    p_ri  = bl_re * bp_im;
    p_ir  = bl_im * bp_re;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= opsa_pkg::ST_CLEAR;
      cells_in_use <= opsa_pkg::CELLS_RESET;
      clr_addr     <= '0;
      cnt          <= '0;
      sat          <= 1'b0;
      v1           <= 1'b0;
      v2           <= 1'b0;
      out_valid    <= 1'b0;
      res_status   <= opsa_pkg::STATUS_DONE;
    end else begin
      state <= state_next;
      if (cfg_wr_en) cells_in_use <= cfg_wr_data;
      if (state == opsa_pkg::ST_CLEAR) clr_addr <= clr_addr + 1'b1;

      v1 <= (state == opsa_pkg::ST_ACC);
      v2 <= v1;
      if (v2 && (ovf_re || ovf_im)) sat <= 1'b1;

      // output valid: load on a new beat, drop once taken
      if ((state == opsa_pkg::ST_RD_DATA || state == opsa_pkg::ST_RES) && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      case (state)
        opsa_pkg::ST_IDLE: begin
          cnt <= '0;
          sat <= 1'b0;
          if (accept && !idx_ok) res_status <= opsa_pkg::STATUS_DROP;
        end
        opsa_pkg::ST_ACC: begin
          cnt <= cnt + 1'b1;
        end
        opsa_pkg::ST_DRAIN: begin
          res_status <= sat ? opsa_pkg::STATUS_SAT : opsa_pkg::STATUS_DONE;
        end
        opsa_pkg::ST_RD_DATA: begin
          if (out_free) cnt <= cnt + 1'b1;
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cell_sel <= CELL_W'(cell_index[11:0]);
      wgt      <= weight;
      b_re[0]  <= basis_0_re;
      b_im[0]  <= basis_0_im;
      b_re[1]  <= basis_1_re;
      b_im[1]  <= basis_1_im;
      b_re[2]  <= basis_2_re;
      b_im[2]  <= basis_2_im;
      b_re[3]  <= basis_3_re;
      b_im[3]  <= basis_3_im;
    end

    // pipe
    a1    <= raddr;
    s1_re <= {p_rr[31], p_rr} + {p_ii[31], p_ii};
    s1_im <= {p_ri[31], p_ri} - {p_ir[31], p_ir};
    a2    <= a1;
    s2_re <= s1_re * $signed({1'b0, wgt});
    s2_im <= s1_im * $signed({1'b0, wgt});
    s2_acc_re <= ram_rdata[2*ACC_W-1:ACC_W];
    s2_acc_im <= ram_rdata[ACC_W-1:0];

    // output beat
    if (state == opsa_pkg::ST_RD_DATA && out_free) begin
      status   <= opsa_pkg::STATUS_DONE;
      row      <= cnt[3:2];
      col      <= cnt[1:0];
      value_re <= ram_rdata[2*ACC_W-1:ACC_W];
      value_im <= ram_rdata[ACC_W-1:0];
      last     <= (cnt == ENT_LAST);
    end else if (state == opsa_pkg::ST_RES && out_free) begin
      status   <= res_status;
      row      <= '0;
      col      <= '0;
      value_re <= '0;
      value_im <= '0;
      last     <= 1'b1;
    end
  end

  opsa_ram #(
    .WIDTH (2 * ACC_W),
    .DEPTH (DEPTH)
  ) u_grid (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (rd_issue),
    .raddr (raddr),
    .rdata (ram_rdata)
  );

`ifndef ASSERT_OFF
  // write-back never collides with a read of the same entry
  a_no_rw_collide: assert property (@(posedge clk) disable iff (rst)
    (v2 && rd_issue) |-> (a2 != raddr))
    else $error("read and write-back hit the same entry");

  // RAM writes come only from the sweep or the pipe
  a_write_source: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == opsa_pkg::ST_CLEAR || v2))
    else $error("unexpected RAM write");

  // second pipe stage follows the first
  a_pipe_order: assert property (@(posedge clk) disable iff (rst)
    v2 |-> $past(v1))
    else $error("pipe stage 2 valid without stage 1");

  // status beat is only produced after the pipe has drained
  a_drained: assert property (@(posedge clk) disable iff (rst)
    (state == opsa_pkg::ST_RES) |-> (!v1 && !v2))
    else $error("status beat with write-back still in flight");
`endif

endmodule

@@ sim/opsa_checker.sv @@
`timescale 1ns / 100ps

// Watches both channels and the register port, keeps its own copy of the
// grid and compares every output beat with the oldest prediction.
module opsa_checker
  import opsa_pkg::*;
#(
  parameter int GRID_CELLS = GRID_CELLS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [12:0]        cfg_wr_data,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic               action,
  input  logic signed [12:0] cell_index,
  input  logic [15:0]        weight,
  input  logic signed [15:0] basis_0_re,
  input  logic signed [15:0] basis_0_im,
  input  logic signed [15:0] basis_1_re,
  input  logic signed [15:0] basis_1_im,
  input  logic signed [15:0] basis_2_re,
  input  logic signed [15:0] basis_2_im,
  input  logic signed [15:0] basis_3_re,
  input  logic signed [15:0] basis_3_im,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [1:0]         status,
  input  logic [1:0]         row,
  input  logic [1:0]         col,
  input  logic signed [47:0] value_re,
  input  logic signed [47:0] value_im,
  input  logic               last,
  output int                 errors,
  output int                 pending
);

  localparam longint ACC_HI = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint ACC_LO = -ACC_HI - 1;

  typedef struct packed {
    status_t     st;
    logic [1:0]  r;
    logic [1:0]  c;
    logic [47:0] re;
    logic [47:0] im;
    logic        lst;
  } entry_beat_t;

  entry_beat_t beats_due[$];
  longint      cell_re[int];
  longint      cell_im[int];
  logic [12:0] cells_limit;

  initial begin
    errors  = 0;
    pending = 0;
    cells_limit = CELLS_RESET;
  end

  task automatic report(input string what, input logic [47:0] got, input logic [47:0] want);
    errors++;
    $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
  endtask

  // round half up from 42 to 30 fraction bits
  function automatic longint round_q30(input longint v);
    return (v + 2048) >>> 12;
  endfunction

  function automatic logic add_clamped(input int key, input longint d, input logic imag);
    longint s;
    logic   clip;
    s = (imag ? (cell_im.exists(key) ? cell_im[key] : 0)
              : (cell_re.exists(key) ? cell_re[key] : 0)) + d;
    clip = 1'b0;
    if (s > ACC_HI) begin
      s = ACC_HI;
      clip = 1'b1;
    end else if (s < ACC_LO) begin
      s = ACC_LO;
      clip = 1'b1;
    end
    if (imag) cell_im[key] = s;
    else cell_re[key] = s;
    return clip;
  endfunction

  // predict the beats caused by one accepted input beat
  task automatic predict_item();
    longint      lim, idx, w, pr, pi;
    longint      br[ORDER];
    longint      bi[ORDER];
    logic        clip;
    int          key;
    entry_beat_t b;
    lim = (cells_limit > GRID_CELLS) ? longint'(GRID_CELLS) : longint'(cells_limit);
    idx = longint'(cell_index);
    b = '0;
    b.lst = 1'b1;
    if (idx < 0 || idx >= lim) begin
      b.st = STATUS_DROP;
      beats_due.push_back(b);
    end else if (action == ACT_READ) begin
      for (int e = 0; e < ENTRIES; e++) begin
        key = int'(idx) * ENTRIES + e;
        b.st  = STATUS_DONE;
        b.r   = 2'(e / ORDER);
        b.c   = 2'(e % ORDER);
        b.re  = cell_re.exists(key) ? cell_re[key][47:0] : '0;
        b.im  = cell_im.exists(key) ? cell_im[key][47:0] : '0;
        b.lst = (e == ENTRIES - 1);
        beats_due.push_back(b);
      end
    end else begin
      br[0] = basis_0_re; bi[0] = basis_0_im;
      br[1] = basis_1_re; bi[1] = basis_1_im;
      br[2] = basis_2_re; bi[2] = basis_2_im;
      br[3] = basis_3_re; bi[3] = basis_3_im;
      w = longint'(weight);
      clip = 1'b0;
      for (int l = 0; l < ORDER; l++) begin
        for (int lp = 0; lp < ORDER; lp++) begin
          // conj(b[l]) * b[l']
          pr = br[l] * br[lp] + bi[l] * bi[lp];
          pi = br[l] * bi[lp] - bi[l] * br[lp];
          key = int'(idx) * ENTRIES + l * ORDER + lp;
          if (add_clamped(key, round_q30(pr * w), 1'b0)) clip = 1'b1;
          if (add_clamped(key, round_q30(pi * w), 1'b1)) clip = 1'b1;
        end
      end
      b.st = clip ? STATUS_SAT : STATUS_DONE;
      beats_due.push_back(b);
    end
  endtask

  always @(posedge clk) begin
    entry_beat_t want;
    if (!rst) begin
      if (cfg_wr_en) cells_limit = cfg_wr_data;
      if (in_valid && !in_stall) predict_item();
      if (out_valid && !out_stall) begin
        if (beats_due.size() == 0) begin
          report("unexpected output beat", 48'(status), 48'd0);
        end else begin
          want = beats_due.pop_front();
          if (status !== want.st) report("status", 48'(status), 48'(want.st));
          if (row !== want.r) report("row", 48'(row), 48'(want.r));
          if (col !== want.c) report("col", 48'(col), 48'(want.c));
          if (value_re !== want.re) report("value_re", value_re, want.re);
          if (value_im !== want.im) report("value_im", value_im, want.im);
          if (last !== want.lst) report("last", 48'(last), 48'(want.lst));
        end
      end
      pending = beats_due.size();
    end
  end

endmodule

@@ sim/tb_outer_product_scatter_accumulate.sv @@
`timescale 1ns / 100ps

module tb_outer_product_scatter_accumulate;
  import opsa_pkg::*;

  // nothing is accepted during the clearing sweep after reset
  localparam int STALL_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 40;

  logic               clk;
  logic               rst;
  logic               cfg_wr_en;
  logic [12:0]        cfg_wr_data;
  logic               in_valid;
  logic               in_stall;
  logic               action;
  logic signed [12:0] cell_index;
  logic [15:0]        weight;
  logic signed [15:0] b0r, b0i, b1r, b1i, b2r, b2i, b3r, b3i;
  logic               out_valid;
  logic               out_stall;
  logic [1:0]         status;
  logic [1:0]         row;
  logic [1:0]         col;
  logic signed [47:0] value_re;
  logic signed [47:0] value_im;
  logic               last;
  int                 errors;
  int                 pending;
  logic               quiet;
  int                 idle_cycles;
  int                 limit_now;

  outer_product_scatter_accumulate i_dut (
    .clk, .rst, .cfg_wr_en, .cfg_wr_data, .in_valid, .in_stall, .action,
    .cell_index, .weight,
    .basis_0_re(b0r), .basis_0_im(b0i), .basis_1_re(b1r), .basis_1_im(b1i),
    .basis_2_re(b2r), .basis_2_im(b2i), .basis_3_re(b3r), .basis_3_im(b3i),
    .out_valid, .out_stall, .status, .row, .col, .value_re, .value_im, .last
  );

  opsa_checker i_checker (
    .clk, .rst, .cfg_wr_en, .cfg_wr_data, .in_valid, .in_stall, .action,
    .cell_index, .weight,
    .basis_0_re(b0r), .basis_0_im(b0i), .basis_1_re(b1r), .basis_1_im(b1i),
    .basis_2_re(b2r), .basis_2_im(b2i), .basis_3_re(b3r), .basis_3_im(b3i),
    .out_valid, .out_stall, .status, .row, .col, .value_re, .value_im, .last,
    .errors, .pending
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // receiver stalls at random unless in a quiet stretch
  always @(posedge clk) begin
    out_stall <= !quiet && ($urandom_range(99) < 32);
  end

  // watchdog on cycles with no beat moving on either side
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // one input beat, with random gaps ahead of it
  task automatic send_beat(input action_t act, input logic [12:0] idx, input logic [15:0] w,
                           input logic [127:0] basis);
    while (!quiet && $urandom_range(99) < 32) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    action     <= act;
    cell_index <= idx;
    weight     <= w;
    {b0r, b0i, b1r, b1i, b2r, b2i, b3r, b3i} <= basis;
    do @(posedge clk); while (in_stall);
  endtask

  // hold the sender until everything expected has come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_cells(input logic [12:0] n);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= n;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    @(posedge clk);
    limit_now = (n > 4096) ? 4096 : int'(n);
  endtask

  task automatic random_beat();
    logic [12:0]  idx;
    action_t      act;
    act = ($urandom_range(3) == 0) ? ACT_READ : ACT_ACCUM;
    if ($urandom_range(9) < 7 && limit_now > 0)
      idx = 13'($urandom_range((limit_now > 12 ? 12 : limit_now) - 1));
    else
      idx = 13'($urandom);
    send_beat(act, idx, 16'($urandom), {$urandom, $urandom, $urandom, $urandom});
  endtask

  initial begin
    rst = 1'b1;
    quiet = 1'b0;
    idle_cycles = 0;
    limit_now = 4096;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_valid = 1'b0;
    out_stall = 1'b0;
    action = ACT_ACCUM;
    cell_index = '0;
    weight = '0;
    {b0r, b0i, b1r, b1i, b2r, b2i, b3r, b3i} = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: field extremes, both actions, dropped indices
    send_beat(ACT_READ, 13'd7, 16'hFFFF, '1);
    send_beat(ACT_ACCUM, 13'd0, 16'hFFFF, {8{16'h8000}});
    send_beat(ACT_ACCUM, 13'd0, 16'hFFFF, {8{16'h7FFF}});
    send_beat(ACT_ACCUM, 13'd0, 16'h0000, {4{16'h8000, 16'h7FFF}});
    send_beat(ACT_ACCUM, 13'd4095, 16'h1000, {16'h7FFF, 16'h8000, 16'h0001, 16'hFFFF,
                                             16'h0000, 16'h4000, 16'hC000, 16'h1234});
    send_beat(ACT_ACCUM, 13'h1FFF, 16'h1000, '1);
    send_beat(ACT_READ, 13'h1000, 16'h0, '0);
    send_beat(ACT_READ, 13'd0, 16'h0, '0);
    send_beat(ACT_READ, 13'd4095, 16'h0, '0);

    set_cells(13'd1);
    send_beat(ACT_READ, 13'd0, 16'h0, '0);
    send_beat(ACT_ACCUM, 13'd1, 16'hFFFF, '1);
    send_beat(ACT_READ, 13'd1, 16'h0, '0);

    set_cells(13'd0);
    send_beat(ACT_ACCUM, 13'd0, 16'h1000, '1);
    send_beat(ACT_READ, 13'd0, 16'h0, '0);

    set_cells(13'h1FFF);
    send_beat(ACT_READ, 13'd4095, 16'h0, '0);
    send_beat(ACT_ACCUM, 13'h0FFF, 16'h8000, {8{16'h7FFF}});

    // largest updates of both signs into one cell
    set_cells(13'd4096);
    for (int k = 0; k < 8; k++)
      send_beat(ACT_ACCUM, 13'd3, 16'hFFFF, {{2{16'h8000}}, {2{16'h7FFF}}, {4{16'h0000}}});
    send_beat(ACT_READ, 13'd3, 16'h0, '0);

    // random phases over several cell counts, one stretch without gaps
    set_cells(13'd5);
    for (int k = 0; k < 70; k++) random_beat();
    set_cells(13'd64);
    quiet = 1'b1;
    for (int k = 0; k < 60; k++) random_beat();
    quiet = 1'b0;
    set_cells(13'd4096);
    for (int k = 0; k < 70; k++) random_beat();

    drain();
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
